// ===== src/priority_thread_scheduler_unit_macros.svh =====
// Assertion macros for the priority thread scheduler checker
`ifndef PRIORITY_THREAD_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_THREAD_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, checked out of reset
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== src/pts_pkg.sv =====
// Shared types and constants for the priority thread scheduler
package pts_pkg;

    localparam int PTS_QUEUE_DEPTH = 16;

    localparam logic [2:0] ADDR_MAX_WORKERS = 3'd0;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_YIELD  = 2'd1;
    localparam logic [1:0] KIND_EXIT   = 2'd2;
    localparam logic [1:0] KIND_START  = 2'd3;

    localparam logic [1:0] ACT_RETURN = 2'd0;
    localparam logic [1:0] ACT_RUN    = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOT_INIT = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INSERT
    } pts_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic insert;
    } pts_cmd_t;

    typedef struct packed {
        logic yield_switch;
    } pts_stat_t;

endpackage

// ===== src/pts_ctrl.sv =====
// Control state machine for the priority thread scheduler
module pts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  pts_pkg::pts_stat_t stat,
    output pts_pkg::pts_cmd_t  cmd
);
    import pts_pkg::*;

    pts_state_t state_reg;
    pts_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = stat.yield_switch ? ST_INSERT : ST_IDLE;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/pts_datapath.sv =====
// Ready queue, worker count and result registers for the priority thread scheduler
module pts_datapath #(
    parameter int QUEUE_DEPTH = pts_pkg::PTS_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pts_pkg::pts_cmd_t  cmd,
    output pts_pkg::pts_stat_t stat,
    input  logic [6:0]        max_workers,
    input  logic [1:0]        kind,
    input  logic [7:0]        thread_id,
    input  logic [7:0]        priority_req,
    output logic [1:0]        action,
    output logic [7:0]        next_thread,
    output logic              spawn_worker,
    output logic [1:0]        status,
    output logic [6:0]        worker_count,
    output logic [4:0]        queue_count
);
    import pts_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0]   cell_reg [QUEUE_DEPTH];
    logic [15:0]   ins_cell [QUEUE_DEPTH];
    logic [15:0]   pop_cell [QUEUE_DEPTH];
    logic          le      [QUEUE_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [6:0]    workers_reg;
    logic [6:0]    workers_next;
    logic [1:0]    kind_reg;
    logic [7:0]    tid_reg;
    logic [7:0]    prio_reg;
    logic [1:0]    action_reg;
    logic [7:0]    next_thread_reg;
    logic          spawn_reg;
    logic [1:0]    status_reg;
    logic [6:0]    worker_count_reg;
    logic [4:0]    queue_count_reg;

    logic          not_init;
    logic          empty;
    logic          full;
    logic          do_pop;
    logic          do_insert;
    logic          spawn;
    logic [1:0]    act;
    logic [1:0]    stat_code;
    logic [31:0]   count_ext;
    logic [15:0]   new_entry;

    assign new_entry = {prio_reg, tid_reg};

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign le[i] = (CW'(i) < count_reg) && (cell_reg[i][15:8] <= prio_reg);
        if (i == 0)
        begin : g_head
            assign ins_cell[i] = le[i] ? cell_reg[i] : new_entry;
        end
        else
        begin : g_body
            assign ins_cell[i] = le[i]     ? cell_reg[i] :
                                 le[i - 1] ? new_entry   : cell_reg[i - 1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign pop_cell[i] = cell_reg[i];
        end
        else
        begin : g_shift
            assign pop_cell[i] = cell_reg[i + 1];
        end
    end

    assign not_init = (max_workers == 7'd0);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg >= CW'(QUEUE_DEPTH));

    always_comb
    begin
        do_pop       = 1'b0;
        do_insert    = 1'b0;
        spawn        = 1'b0;
        act          = ACT_RETURN;
        stat_code    = STAT_OK;
        count_next   = count_reg;
        workers_next = workers_reg;
        stat.yield_switch = !not_init && (kind_reg == KIND_YIELD) && !empty
                            && (cell_reg[0][15:8] <= prio_reg);
        if (not_init)
        begin
            stat_code = STAT_NOT_INIT;
        end
        else
        begin
            unique case (kind_reg)
                KIND_CREATE:
                begin
                    if (full)
                    begin
                        stat_code = STAT_FULL;
                    end
                    else
                    begin
                        do_insert  = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (workers_reg < max_workers)
                        begin
                            spawn        = 1'b1;
                            workers_next = workers_reg + 7'd1;
                        end
                    end
                end
                KIND_YIELD:
                begin
                    if (stat.yield_switch)
                    begin
                        do_pop     = 1'b1;
                        act        = ACT_RUN;
                        count_next = count_reg - 1'b1;
                    end
                end
                KIND_EXIT, KIND_START:
                begin
                    if (!empty)
                    begin
                        do_pop     = 1'b1;
                        act        = ACT_RUN;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        act = ACT_END;
                        if (workers_reg != 7'd0)
                        begin
                            workers_next = workers_reg - 7'd1;
                        end
                    end
                end
                default:
                begin
                    act = ACT_RETURN;
                end
            endcase
        end
    end

    assign count_ext = stat.yield_switch ? 32'(count_reg) : 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            workers_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg   <= count_next;
            workers_reg <= workers_next;
        end
        else if (cmd.insert)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            tid_reg  <= thread_id;
            prio_reg <= priority_req;
        end
        if (cmd.commit)
        begin
            action_reg       <= act;
            next_thread_reg  <= do_pop ? cell_reg[0][7:0] : 8'd0;
            spawn_reg        <= spawn;
            status_reg       <= stat_code;
            worker_count_reg <= workers_next;
            queue_count_reg  <= count_ext[4:0];
        end
        if ((cmd.commit && do_insert) || cmd.insert)
        begin
            cell_reg <= ins_cell;
        end
        else if (cmd.commit && do_pop)
        begin
            cell_reg <= pop_cell;
        end
    end

    assign action       = action_reg;
    assign next_thread  = next_thread_reg;
    assign spawn_worker = spawn_reg;
    assign status       = status_reg;
    assign worker_count = worker_count_reg;
    assign queue_count  = queue_count_reg;

endmodule

// ===== src/priority_thread_scheduler_unit.sv =====
// Priority thread scheduler: sorted ready queue of threads plus kernel worker count
//
// Usage: set max_workers through the APB port (byte address 0) before sending
// events; while it is zero every event reports not initialized. Each event on
// the input channel (kind, thread_id, priority_req) produces exactly one result
// on the output channel. A transfer happens at a clock edge with valid high and
// stall low. The queue is a row of registers kept sorted by priority, lowest
// number first and first-in first-out among equals; one compare per slot
// finds the insert point, so an insert or a pop shifts the whole row at once.
// An event is captured into input registers and its result is registered once the
// output slot is free; no new event is taken meanwhile, and a switching yield waits
// for the caller's re-insert, as the head pop and re-insert use the same slot row.
// A pending result sits in an output register; while the receiver stalls the
// result holds, the block takes at most one more event and then raises in_stall.
// Reset empties the queue, clears the worker count and max_workers, and drops
// any pending result. Queue slots hold no reset value.
module priority_thread_scheduler_unit #(
    parameter int QUEUE_DEPTH = pts_pkg::PTS_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  thread_id,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [7:0]  next_thread,
    output logic        spawn_worker,
    output logic [1:0]  status,
    output logic [6:0]  worker_count,
    output logic [4:0]  queue_count
);
    import pts_pkg::*;

    pts_cmd_t   cmd;
    pts_stat_t  stat;
    logic [6:0] max_workers_reg;
    logic       hit_max;

    assign pready  = 1'b1;
    assign hit_max = (paddr[2] == ADDR_MAX_WORKERS[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_workers_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && hit_max)
        begin
            max_workers_reg <= pwdata[6:0];
        end
    end

    assign prdata = hit_max ? {25'd0, max_workers_reg} : 32'd0;

    pts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pts_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .max_workers  (max_workers_reg),
        .kind         (kind),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .action       (action),
        .next_thread  (next_thread),
        .spawn_worker (spawn_worker),
        .status       (status),
        .worker_count (worker_count),
        .queue_count  (queue_count)
    );

endmodule

// ===== src/pts_checker.sv =====
// Port-level checks for the priority thread scheduler, bound to the top level
`include "priority_thread_scheduler_unit_macros.svh"

module pts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] action,
    input logic       spawn_worker,
    input logic [1:0] status,
    input logic [4:0] queue_count
);
    import pts_pkg::*;

    `PTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `PTS_ASSERT_NOW(a_err_returns, clk, rst_n, out_valid && (status != STAT_OK), action == ACT_RETURN)
    `PTS_ASSERT_NOW(a_spawn_ok, clk, rst_n, out_valid && spawn_worker, (status == STAT_OK) && (action == ACT_RETURN))
    `PTS_ASSERT_NOW(a_end_empty, clk, rst_n, out_valid && (action == ACT_END), queue_count == 5'd0)

endmodule

bind priority_thread_scheduler_unit pts_checker u_pts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .action       (action),
    .spawn_worker (spawn_worker),
    .status       (status),
    .queue_count  (queue_count)
);

// ===== tb/sv/tb_priority_thread_scheduler_unit.sv =====
// Self-checking testbench for the priority thread scheduler: directed and random event traffic
`timescale 1ns / 100ps

module tb_priority_thread_scheduler_unit;

    import pts_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MISMATCH_SHOWN = 10;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] next_thread;
        logic       spawn_worker;
        logic [1:0] status;
        logic [6:0] worker_count;
        logic [4:0] queue_count;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [7:0]  thread_id;
    logic [7:0]  priority_req;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  action;
    logic [7:0]  next_thread;
    logic        spawn_worker;
    logic [1:0]  status;
    logic [6:0]  worker_count;
    logic [4:0]  queue_count;

    logic [15:0]   ready_list[$];
    logic [6:0]    worker_total;
    logic [6:0]    worker_limit;
    sched_result_t pending_results[$];
    int            mismatch_count;
    bit            send_gaps_on;
    bit            result_stalls_on;

    priority_thread_scheduler_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .next_thread  (next_thread),
        .spawn_worker (spawn_worker),
        .status       (status),
        .worker_count (worker_count),
        .queue_count  (queue_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void ready_insert(logic [7:0] tid, logic [7:0] prio);
        int pos;
        pos = 0;
        while (pos < ready_list.size() && ready_list[pos][15:8] <= prio)
            pos++;
        ready_list.insert(pos, {prio, tid});
    endfunction

    function automatic sched_result_t schedule_event(logic [1:0] ev_kind, logic [7:0] tid,
                                                     logic [7:0] prio);
        sched_result_t r;
        logic [15:0]   head;
        r = '0;
        r.action = ACT_RETURN;
        r.status = STAT_OK;
        if (worker_limit == 0) begin
            r.status = STAT_NOT_INIT;
        end
        else if (ev_kind == KIND_CREATE) begin
            if (ready_list.size() >= PTS_QUEUE_DEPTH) begin
                r.status = STAT_FULL;
            end
            else begin
                ready_insert(tid, prio);
                if (worker_total < worker_limit) begin
                    worker_total++;
                    r.spawn_worker = 1'b1;
                end
            end
        end
        else if (ev_kind == KIND_YIELD) begin
            if (ready_list.size() > 0 && ready_list[0][15:8] <= prio) begin
                head = ready_list.pop_front();
                r.next_thread = head[7:0];
                ready_insert(tid, prio);
                r.action = ACT_RUN;
            end
        end
        else begin
            if (ready_list.size() > 0) begin
                head = ready_list.pop_front();
                r.next_thread = head[7:0];
                r.action = ACT_RUN;
            end
            else begin
                r.action = ACT_END;
                if (worker_total > 0)
                    worker_total--;
            end
        end
        r.worker_count = worker_total;
        r.queue_count = 5'(ready_list.size());
        return r;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN)
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{action, next_thread, spawn_worker, status, worker_count, queue_count};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_SHOWN)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            else begin
                want = pending_results.pop_front();
                check_field("action", 8'(want.action), 8'(got.action));
                check_field("next_thread", want.next_thread, got.next_thread);
                check_field("spawn_worker", 8'(want.spawn_worker), 8'(got.spawn_worker));
                check_field("status", 8'(want.status), 8'(got.status));
                check_field("worker_count", 8'(want.worker_count), 8'(got.worker_count));
                check_field("queue_count", 8'(want.queue_count), 8'(got.queue_count));
            end
        end
    end

    initial
    begin
        forever begin
            @(posedge clk);
            if (result_stalls_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("priority_thread_scheduler_unit: mismatch");
        $finish;
    end

    task automatic send_event(logic [1:0] ev_kind, logic [7:0] tid, logic [7:0] prio);
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= ev_kind;
        thread_id    <= tid;
        priority_req <= prio;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_results.push_back(schedule_event(ev_kind, tid, prio));
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // hold traffic, write the limit, then read it back
    task automatic set_max_workers(logic [6:0] value);
        wait_results_done();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_WORKERS;
        pwdata  <= {25'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        worker_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("max_workers readback", 8'(value), 8'(prdata[6:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_not_initialized();
        send_event(KIND_CREATE, 8'd255, 8'd0);
        send_event(KIND_YIELD, 8'd0, 8'd255);
        send_event(KIND_EXIT, 8'd255, 8'd255);
        send_event(KIND_START, 8'd0, 8'd0);
    endtask

    task automatic test_empty_queue_and_worker_floor();
        set_max_workers(7'd1);
        send_event(KIND_YIELD, 8'd10, 8'd5);
        send_event(KIND_EXIT, 8'd0, 8'd0);
        send_event(KIND_CREATE, 8'd1, 8'd5);
        send_event(KIND_YIELD, 8'd2, 8'd4);
        send_event(KIND_START, 8'd0, 8'd0);
        send_event(KIND_START, 8'd0, 8'd0);
    endtask

    task automatic test_lowered_limit_and_full_queue();
        set_max_workers(7'd2);
        send_event(KIND_CREATE, 8'd0, 8'd255);
        send_event(KIND_CREATE, 8'd255, 8'd128);
        set_max_workers(7'd1);
        for (int i = 2; i < PTS_QUEUE_DEPTH; i++)
            send_event(KIND_CREATE, 8'(i * 17), 8'((i % 4) * 85));
        send_event(KIND_CREATE, 8'd99, 8'd0);
        send_event(KIND_YIELD, 8'd200, 8'd255);
        send_event(KIND_YIELD, 8'd201, 8'd0);
    endtask

    task automatic random_phase(int count, logic [6:0] limit, bit quiet_tail, bit mid_pause);
        int         sent;
        int         burst;
        int         bias;
        int         roll;
        bit         narrow;
        logic [7:0] base;
        logic [1:0] ev_kind;
        logic [7:0] prio;
        set_max_workers(limit);
        sent = 0;
        while (sent < count) begin
            bias   = $urandom_range(0, 2);
            narrow = $urandom_range(0, 1);
            base   = 8'($urandom_range(0, 252));
            burst  = $urandom_range(4, 24);
            send_gaps_on     = !quiet_tail && $urandom_range(0, 3) != 0;
            result_stalls_on = !quiet_tail && $urandom_range(0, 3) != 0;
            for (int i = 0; i < burst && sent < count; i++) begin
                roll = $urandom_range(0, 99);
                if (bias == 2)
                    ev_kind = 2'($urandom_range(0, 3));
                else if (roll < (bias == 0 ? 70 : 15))
                    ev_kind = KIND_CREATE;
                else if (roll < (bias == 0 ? 85 : 35))
                    ev_kind = KIND_YIELD;
                else
                    ev_kind = $urandom_range(0, 1) ? KIND_EXIT : KIND_START;
                prio = narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
                send_event(ev_kind, 8'($urandom_range(0, 255)), prio);
                sent++;
                if (mid_pause && sent == count / 2)
                    wait_results_done();
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(250, 7'd64, 1'b0, 1'b1);
        random_phase(200, 7'($urandom_range(2, 63)), 1'b0, 1'b0);
        random_phase(150, 7'd1, 1'b0, 1'b0);
        random_phase(20, 7'd0, 1'b0, 1'b0);
        random_phase(180, 7'd64, 1'b1, 1'b0);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        kind             = KIND_CREATE;
        thread_id        = '0;
        priority_req     = '0;
        out_stall        = 1'b0;
        worker_total     = '0;
        worker_limit     = '0;
        mismatch_count   = 0;
        send_gaps_on     = 1'b1;
        result_stalls_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_not_initialized();
        test_empty_queue_and_worker_floor();
        test_lowered_limit_and_full_queue();
        test_random_traffic();

        wait_results_done();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("priority_thread_scheduler_unit: match");
        else
            $display("priority_thread_scheduler_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/pts_pkg.sv
src/pts_ctrl.sv
src/pts_datapath.sv
src/priority_thread_scheduler_unit.sv
src/pts_checker.sv
tb/sv/tb_priority_thread_scheduler_unit.sv
